// ===== design/assert_macros.svh =====
// assertion macros for the bar graph renderer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/spbg_pkg.sv =====
package spbg_pkg;

    // fixed field widths
    localparam int BAND_W   = 4;
    localparam int LEVEL_W  = 16;
    localparam int LED_W    = 7;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 24;
    localparam int THR_W    = 8;
    localparam int FRAC_W   = 8;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int COLOR_REGS = 6;

    typedef enum logic [2:0] {
        REG_TOP_ROW_COLOR     = 3'd0,
        REG_SECOND_ROW_COLOR  = 3'd1,
        REG_THIRD_ROW_COLOR   = 3'd2,
        REG_FOURTH_ROW_COLOR  = 3'd3,
        REG_FIFTH_ROW_COLOR   = 3'd4,
        REG_BOTTOM_ROW_COLOR  = 3'd5,
        REG_PARTIAL_THRESHOLD = 3'd6
    } t_reg_idx;

    localparam logic [COLOR_W-1:0] COLOR_RESET [COLOR_REGS] = '{
        24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h80FF00, 24'h00FF00, 24'h00FF80
    };
    localparam logic [THR_W-1:0] THR_RESET = 8'd12;

    typedef struct packed {
        logic [BAND_W-1:0]  band_index;
        logic [LEVEL_W-1:0] band_level;
    } t_in_beat;

    typedef struct packed {
        logic [LED_W-1:0]  led_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_led;
    } t_out_beat;

endpackage

// ===== design/spbg_row_shade.sv =====
module spbg_row_shade #(
    parameter int FULL_W = 3
) (
    input  logic [FULL_W-1:0]             i_full,
    input  logic [FULL_W-1:0]             i_pos,
    input  logic [spbg_pkg::FRAC_W-1:0]   i_frac,
    input  logic [spbg_pkg::THR_W-1:0]    i_thr,
    input  logic [spbg_pkg::COLOR_W-1:0]  i_color,
    output logic [spbg_pkg::COLOR_W-1:0]  o_rgb
);
    import spbg_pkg::*;

    logic [CHAN_W+FRAC_W-1:0] prod_r;
    logic [CHAN_W+FRAC_W-1:0] prod_g;
    logic [CHAN_W+FRAC_W-1:0] prod_b;

    // scaled channels for the partial row, truncated
    assign prod_r = (CHAN_W+FRAC_W)'(i_color[23:16]) * (CHAN_W+FRAC_W)'(i_frac);
    assign prod_g = (CHAN_W+FRAC_W)'(i_color[15:8])  * (CHAN_W+FRAC_W)'(i_frac);
    assign prod_b = (CHAN_W+FRAC_W)'(i_color[7:0])   * (CHAN_W+FRAC_W)'(i_frac);

    // fully lit, partial or dark
    always_comb begin
        priority if (i_pos < i_full) begin
            o_rgb = i_color;
        end else if (i_pos == i_full && i_frac > i_thr) begin
            o_rgb = {prod_r[CHAN_W+FRAC_W-1:FRAC_W], prod_g[CHAN_W+FRAC_W-1:FRAC_W],
                     prod_b[CHAN_W+FRAC_W-1:FRAC_W]};
        end else begin
            o_rgb = '0;
        end
    end

endmodule

// ===== design/spectrum_bar_graph_renderer_core.sv =====
// channel  | handshake           | payload
// input    | i_in_valid/o_in_stall   | i_in_beat  (band_index, band_level)
// output   | o_out_valid/i_out_stall | o_out_beat (led_index, rgb, last_led)
// config   | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// each band beat yields ROWS_PER_COLUMN output beats, one per cycle unless the output stalls, bottom row first;
// the row counter paces the walk, and the next band follows the top row back to back.
// the input beat loads the row walk registers, and each output beat then goes through the output register.
// bands at or above BAND_COUNT are taken and dropped without output.
// a stalled output holds the row walk; the next band is taken on the top row cycle.
// reset is synchronous: registers return to their default colors and threshold.
`include "assert_macros.svh"

module spectrum_bar_graph_renderer_core #(
    parameter int ROWS_PER_COLUMN = 6,
    parameter int BAND_COUNT      = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  spbg_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output spbg_pkg::t_out_beat                 o_out_beat,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spbg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [spbg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [spbg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import spbg_pkg::*;

    localparam int ROW_W     = $clog2(ROWS_PER_COLUMN);
    localparam int FULL_W    = $clog2(ROWS_PER_COLUMN + 1);
    localparam int H_W       = LEVEL_W + FULL_W;
    localparam int LED_SUM_W = BAND_W + ROW_W + 1;

    // configuration registers
    logic [COLOR_W-1:0] r_color [COLOR_REGS];
    logic [THR_W-1:0]   r_thr;
    t_reg_idx           reg_idx;
    logic               cfg_wr;

    // row walk state
    logic               r_busy;
    logic [BAND_W-1:0]  r_band;
    logic [FULL_W-1:0]  r_full;
    logic [FRAC_W-1:0]  r_frac;
    logic [ROW_W-1:0]   r_row;

    // output register
    logic               r_out_valid;
    t_out_beat          r_out;
    t_out_beat          n_out;

    logic               in_fire;
    logic               in_keep;
    logic               adv;
    logic               last_row;
    logic [H_W-1:0]     h_prod;
    logic [H_W-1:0]     h_sat;
    logic [FULL_W-1:0]  pos;
    logic [2:0]         color_sel;
    logic [COLOR_W-1:0] row_rgb;
    logic [LED_SUM_W-1:0] led_sum;

    // register decode
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COLOR_REGS; i++) begin
                r_color[i] <= COLOR_RESET[i];
            end
            r_thr <= THR_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TOP_ROW_COLOR, REG_SECOND_ROW_COLOR, REG_THIRD_ROW_COLOR,
                REG_FOURTH_ROW_COLOR, REG_FIFTH_ROW_COLOR, REG_BOTTOM_ROW_COLOR: begin
                    r_color[reg_idx] <= pwdata[COLOR_W-1:0];
                end
                REG_PARTIAL_THRESHOLD: begin
                    r_thr <= pwdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_TOP_ROW_COLOR, REG_SECOND_ROW_COLOR, REG_THIRD_ROW_COLOR,
            REG_FOURTH_ROW_COLOR, REG_FIFTH_ROW_COLOR, REG_BOTTOM_ROW_COLOR: begin
                prdata = APB_DATA_W'(r_color[reg_idx]);
            end
            REG_PARTIAL_THRESHOLD: begin
                prdata = APB_DATA_W'(r_thr);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // handshake
    assign last_row   = (r_row == '0);
    assign adv        = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_busy && !(adv && last_row);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign in_keep    = ({{(32-BAND_W){1'b0}}, i_in_beat.band_index} < 32'(BAND_COUNT));

    // column height in q.8, saturated at a full column
    assign h_prod = H_W'(i_in_beat.band_level) * H_W'(ROWS_PER_COLUMN);
    assign h_sat  = (h_prod > H_W'(ROWS_PER_COLUMN * 256)) ?
                    H_W'(ROWS_PER_COLUMN * 256) : h_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_fire && in_keep) begin
            r_busy <= 1'b1;
        end else if (adv && last_row) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && in_keep) begin
            r_band <= i_in_beat.band_index;
            r_full <= h_sat[FRAC_W +: FULL_W];
            r_frac <= h_sat[FRAC_W-1:0];
            r_row  <= ROW_W'(ROWS_PER_COLUMN - 1);
        end else if (adv && !last_row) begin
            r_row  <= r_row - ROW_W'(1);
        end
    end

    // per-row color pick, extra rows reuse the bottom color
    always_comb begin
        if (32'(r_row) < COLOR_REGS) begin
            color_sel = 3'(r_row);
        end else begin
            color_sel = 3'(COLOR_REGS - 1);
        end
    end

    assign pos = FULL_W'(ROWS_PER_COLUMN - 1) - FULL_W'(r_row);

    spbg_row_shade #(
        .FULL_W (FULL_W)
    ) u_shade (
        .i_full  (r_full),
        .i_pos   (pos),
        .i_frac  (r_frac),
        .i_thr   (r_thr),
        .i_color (r_color[color_sel]),
        .o_rgb   (row_rgb)
    );

    // led number wraps at the field width
    assign led_sum = LED_SUM_W'(r_band) * LED_SUM_W'(ROWS_PER_COLUMN) + LED_SUM_W'(r_row);

    always_comb begin
        n_out.led_index = LED_W'(led_sum);
        n_out.red       = row_rgb[23:16];
        n_out.green     = row_rgb[15:8];
        n_out.blue      = row_rgb[7:0];
        n_out.last_led  = last_row;
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // checks
    `ASSERT_NEXT(a_load_bottom, i_clk, i_rst_n, in_fire && in_keep, r_busy && r_row == ROW_W'(ROWS_PER_COLUMN - 1), "band load did not start at bottom row")
    `ASSERT_NEXT(a_adv_out, i_clk, i_rst_n, adv, r_out_valid && o_out_beat.last_led == $past(last_row), "row step did not produce an output beat")
    `ASSERT_NEXT(a_last_free, i_clk, i_rst_n, adv && last_row && !(in_fire && in_keep), !r_busy, "walk did not end after top row")
    `ASSERT_SAME(a_stall_hold, i_clk, i_rst_n, r_busy && i_out_stall && r_out_valid, o_in_stall, "input taken while output blocked")

endmodule
